>>> hw/rtl/adsr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared types and constants of the linear ADSR envelope core: phase codes,
// register indexes, field widths and the sequencer microprogram.
// ----------------------------------------------------------------------------
package adsr_pkg;

  localparam int unsigned MS_W    = 13;
  localparam int unsigned SUS_W   = 16;
  localparam int unsigned LVL_W   = 16;
  localparam int unsigned PH_W    = 2;
  localparam int unsigned CFG_A_W = 2;

  localparam logic [SUS_W-1:0] SUS_FULL = 16'd32768;

  localparam logic [MS_W-1:0]  ATTACK_RST  = 13'd10;
  localparam logic [MS_W-1:0]  DECAY_RST   = 13'd10;
  localparam logic [SUS_W-1:0] SUSTAIN_RST = 16'd16384;
  localparam logic [MS_W-1:0]  RELEASE_RST = 13'd10;

  // envelope phases
  localparam logic [PH_W-1:0] PH_ATTACK  = 2'd0;
  localparam logic [PH_W-1:0] PH_DECAY   = 2'd1;
  localparam logic [PH_W-1:0] PH_SUSTAIN = 2'd2;
  localparam logic [PH_W-1:0] PH_RELEASE = 2'd3;

  // configuration register indexes
  localparam logic [CFG_A_W-1:0] REG_ATTACK  = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_DECAY   = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_SUSTAIN = 2'd2;
  localparam logic [CFG_A_W-1:0] REG_RELEASE = 2'd3;

  // sequencer steps
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FLAGS,
    ST_DIV,
    ST_APPLY,
    ST_EMIT,
    ST_BACK
  } step_t;

  // jump conditions
  typedef enum logic [2:0] {
    JC_NEVER,
    JC_ALWAYS,
    JC_IN_WAIT,
    JC_NO_DIV,
    JC_DIV_MORE,
    JC_OUT_BUSY
  } jcond_t;

  typedef struct packed {
    logic   in_rdy;
    logic   load;
    logic   div;
    logic   apply;
    logic   emit;
    jcond_t cond;
    step_t  target;
  } ctrl_t;

  // microprogram rom
  function automatic ctrl_t seq_rom(input step_t pc);
    ctrl_t c;
    c = '{in_rdy: 1'b0, load: 1'b0, div: 1'b0, apply: 1'b0, emit: 1'b0,
          cond: JC_ALWAYS, target: ST_IDLE};
    unique case (pc)
      ST_IDLE: begin
        c.in_rdy = 1'b1;
        c.cond   = JC_IN_WAIT;
        c.target = ST_IDLE;
      end
      ST_FLAGS: begin
        c.load   = 1'b1;
        c.cond   = JC_NO_DIV;
        c.target = ST_APPLY;
      end
      ST_DIV: begin
        c.div    = 1'b1;
        c.cond   = JC_DIV_MORE;
        c.target = ST_DIV;
      end
      ST_APPLY: begin
        c.apply  = 1'b1;
        c.cond   = JC_NEVER;
      end
      ST_EMIT: begin
        c.emit   = 1'b1;
        c.cond   = JC_OUT_BUSY;
        c.target = ST_EMIT;
      end
      ST_BACK: begin
        c.cond   = JC_ALWAYS;
        c.target = ST_IDLE;
      end
      default: begin
        c.cond   = JC_ALWAYS;
        c.target = ST_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/adsr_envelope_generator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adsr_envelope_generator_core
// Linear ADSR envelope, one sample tick per input transaction.
//
// in_tdata carries the note flags of one tick; every accepted transaction
// gives exactly one out transaction with the level before the tick's step
// and the phase after the note flags. Configuration is written through
// cfg_we/cfg_addr/cfg_wdata; the user must do so only while no tick is in
// flight, which the block itself does not enforce.
// A microcoded sequencer runs each tick: accept, flag decode, a restoring
// divider that retires one quotient bit a cycle (skipped in sustain, in
// release without note-off and for zero times), level update, output
// write and return.
// The output is a register: a finished result waits there while the next
// tick is accepted and computed; if out_tready stays low the sequencer
// holds in its output step until the register frees up.
// Reset (rst_n low, synchronous) restores the register defaults, puts the
// envelope in release at level zero and drops out_tvalid.
// ----------------------------------------------------------------------------
module adsr_envelope_generator_core #(
  parameter int unsigned SAMPLES_PER_MS  = 48,
  parameter int unsigned LEVEL_FRAC_BITS = 23
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [adsr_pkg::CFG_A_W-1:0]  cfg_addr,
  input  wire logic [adsr_pkg::SUS_W-1:0]    cfg_wdata,
  // ticks
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [0] note_on, [1] note_off
  // results
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata   // [15:0] level, [17:16] phase
);

  localparam int unsigned F    = LEVEL_FRAC_BITS;
  localparam int unsigned LW   = F + 1;
  localparam int unsigned OSH  = F - 15;
  localparam int unsigned NMAX = SAMPLES_PER_MS * ((1 << adsr_pkg::MS_W) - 1);
  localparam int unsigned NW   = $clog2(NMAX + 1);
  localparam int unsigned CW   = $clog2(LW + 1);

  localparam logic [LW-1:0] FULL = {1'b1, {F{1'b0}}};
  localparam logic [LW-1:0] ONE  = {{(LW-1){1'b0}}, 1'b1};

  // configuration registers
  logic [adsr_pkg::MS_W-1:0]  attack_ms_r;
  logic [adsr_pkg::MS_W-1:0]  decay_ms_r;
  logic [adsr_pkg::SUS_W-1:0] sustain_r;
  logic [adsr_pkg::MS_W-1:0]  release_ms_r;

  // envelope state
  logic [adsr_pkg::PH_W-1:0] phase_r;
  logic [LW-1:0]             level_r;
  logic [NW-1:0]             rel_rem_r;
  logic [LW-1:0]             rel_step_r;

  // sequencer
  adsr_pkg::step_t pc_r, pc_nxt;
  adsr_pkg::ctrl_t ctrl;
  logic            jump;

  // per tick working registers
  logic                      on_r, off_r;
  logic                      nzero_r, rel_load_r;
  logic [LW-1:0]             div_q_r;
  logic [NW-1:0]             div_rem_r;
  logic [NW-1:0]             div_d_r;
  logic [CW-1:0]             div_cnt_r;
  logic [adsr_pkg::LVL_W-1:0] res_level_r;
  logic [adsr_pkg::PH_W-1:0]  res_phase_r;

  // output register
  logic                       out_valid_r;
  logic [adsr_pkg::LVL_W-1:0] out_level_r;
  logic [adsr_pkg::PH_W-1:0]  out_phase_r;

  // flag decode
  logic [adsr_pkg::SUS_W-1:0] sus_sat;
  logic [LW-1:0]              sus_int;
  logic [NW-1:0]              n_a, n_d, n_r, n_sel;
  logic [LW-1:0]              dvd_sel;
  logic [adsr_pkg::PH_W-1:0]  ph_new;
  logic                       rel_load, need_div, no_div;

  // divider step
  logic [NW:0]   trial, trial_diff;
  logic          trial_ge;

  // level update
  logic [LW-1:0] ramp_st, rel_st;
  logic [LW:0]   att_sum;
  logic          out_busy;

  assign sus_sat = (sustain_r > adsr_pkg::SUS_FULL) ? adsr_pkg::SUS_FULL : sustain_r;
  assign sus_int = LW'(sus_sat) << OSH;

  assign n_a = NW'(SAMPLES_PER_MS) * NW'(attack_ms_r);
  assign n_d = NW'(SAMPLES_PER_MS) * NW'(decay_ms_r);
  assign n_r = NW'(SAMPLES_PER_MS) * NW'(release_ms_r);

  assign rel_load = !on_r && off_r;
  assign ph_new   = on_r ? adsr_pkg::PH_ATTACK : (off_r ? adsr_pkg::PH_RELEASE : phase_r);

  always_comb begin
    n_sel    = n_r;
    dvd_sel  = level_r;
    need_div = 1'b0;
    case (ph_new)
      adsr_pkg::PH_ATTACK: begin
        n_sel    = n_a;
        dvd_sel  = FULL;
        need_div = 1'b1;
      end
      adsr_pkg::PH_DECAY: begin
        n_sel    = n_d;
        dvd_sel  = FULL - sus_int;
        need_div = 1'b1;
      end
      adsr_pkg::PH_RELEASE: begin
        n_sel    = n_r;
        dvd_sel  = level_r;
        need_div = rel_load;
      end
      default: begin
        need_div = 1'b0;
      end
    endcase
  end

  assign no_div = !need_div || (n_sel == '0);

  assign trial      = {div_rem_r, div_q_r[LW-1]};
  assign trial_diff = trial - {1'b0, div_d_r};
  assign trial_ge   = trial >= {1'b0, div_d_r};

  assign ramp_st = nzero_r ? FULL : ((div_q_r == '0) ? ONE : div_q_r);
  assign rel_st  = rel_load_r ? (nzero_r ? level_r : div_q_r) : rel_step_r;
  assign att_sum = {1'b0, level_r} + {1'b0, ramp_st};

  assign out_busy = out_valid_r && !out_tready;

  // sequencer
  assign ctrl = adsr_pkg::seq_rom(pc_r);

  always_comb begin
    case (ctrl.cond)
      adsr_pkg::JC_NEVER:    jump = 1'b0;
      adsr_pkg::JC_ALWAYS:   jump = 1'b1;
      adsr_pkg::JC_IN_WAIT:  jump = !in_tvalid;
      adsr_pkg::JC_NO_DIV:   jump = no_div;
      adsr_pkg::JC_DIV_MORE: jump = (div_cnt_r != CW'(1));
      adsr_pkg::JC_OUT_BUSY: jump = out_busy;
      default:               jump = 1'b1;
    endcase
    pc_nxt = jump ? ctrl.target : adsr_pkg::step_t'(pc_r + 3'd1);
  end

  assign in_tready  = ctrl.in_rdy;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_phase_r, out_level_r};

  // control and envelope state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= adsr_pkg::ST_IDLE;
      attack_ms_r  <= adsr_pkg::ATTACK_RST;
      decay_ms_r   <= adsr_pkg::DECAY_RST;
      sustain_r    <= adsr_pkg::SUSTAIN_RST;
      release_ms_r <= adsr_pkg::RELEASE_RST;
      phase_r      <= adsr_pkg::PH_RELEASE;
      level_r      <= '0;
      rel_rem_r    <= '0;
      rel_step_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      pc_r <= pc_nxt;

      if (cfg_we) begin
        unique case (cfg_addr)
          adsr_pkg::REG_ATTACK:  attack_ms_r  <= cfg_wdata[adsr_pkg::MS_W-1:0];
          adsr_pkg::REG_DECAY:   decay_ms_r   <= cfg_wdata[adsr_pkg::MS_W-1:0];
          adsr_pkg::REG_SUSTAIN: sustain_r    <= cfg_wdata;
          adsr_pkg::REG_RELEASE: release_ms_r <= cfg_wdata[adsr_pkg::MS_W-1:0];
          default: ;
        endcase
      end

      if (ctrl.load) begin
        phase_r <= ph_new;
        if (rel_load) begin
          rel_rem_r <= (n_r == '0) ? NW'(1) : n_r;
        end
      end

      if (ctrl.apply) begin
        if (rel_load_r) begin
          rel_step_r <= rel_st;
        end
        case (phase_r)
          adsr_pkg::PH_ATTACK: begin
            if (att_sum > {1'b0, FULL}) begin
              level_r <= FULL;
              phase_r <= adsr_pkg::PH_DECAY;
            end else begin
              level_r <= att_sum[LW-1:0];
            end
          end
          adsr_pkg::PH_DECAY: begin
            if ((level_r < ramp_st) || ((level_r - ramp_st) < sus_int)) begin
              level_r <= sus_int;
              phase_r <= adsr_pkg::PH_SUSTAIN;
            end else begin
              level_r <= level_r - ramp_st;
            end
          end
          adsr_pkg::PH_SUSTAIN: ;
          default: begin
            if (rel_rem_r != '0) begin
              level_r   <= (level_r > rel_st) ? (level_r - rel_st) : '0;
              rel_rem_r <= rel_rem_r - NW'(1);
            end
          end
        endcase
      end

      if (ctrl.emit && !out_busy) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (ctrl.in_rdy && in_tvalid) begin
      on_r  <= in_tdata[0];
      off_r <= in_tdata[1];
    end

    if (ctrl.load) begin
      res_level_r <= level_r[OSH +: adsr_pkg::LVL_W];
      res_phase_r <= ph_new;
      nzero_r     <= (n_sel == '0);
      rel_load_r  <= rel_load;
      div_q_r     <= dvd_sel;
      div_rem_r   <= '0;
      div_d_r     <= n_sel;
      div_cnt_r   <= CW'(LW);
    end

    if (ctrl.div) begin
      div_rem_r <= trial_ge ? trial_diff[NW-1:0] : trial[NW-1:0];
      div_q_r   <= {div_q_r[LW-2:0], trial_ge};
      div_cnt_r <= div_cnt_r - CW'(1);
    end

    if (ctrl.emit && !out_busy) begin
      out_level_r <= res_level_r;
      out_phase_r <= res_phase_r;
    end
  end

endmodule
`default_nettype wire
